FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the tunnel session handshake engine.
// No dependencies; expects clk_i and rst_ni in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define TSHF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define TSHF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hdl/tshf_pkg.sv
// Types and codes of the tunnel session handshake engine.
// No dependencies; used by tunnel_session_handshake_fsm_unit.
package tshf_pkg;

  // Session states, one-hot internally.
  typedef enum logic [7:0] {
    ST_LOGIN_SENT     = 8'b0000_0001,
    ST_RESPONSE_SENT  = 8'b0000_0010,
    ST_CLIENT_CONN    = 8'b0000_0100,
    ST_IDLE           = 8'b0000_1000,
    ST_LISTEN         = 8'b0001_0000,
    ST_CHALLENGE_SENT = 8'b0010_0000,
    ST_SERVER_CONN    = 8'b0100_0000,
    ST_STALE          = 8'b1000_0000
  } state_e;

  // External state codes.
  localparam logic [2:0] CODE_LOGIN_SENT     = 3'd0;
  localparam logic [2:0] CODE_RESPONSE_SENT  = 3'd1;
  localparam logic [2:0] CODE_CLIENT_CONN    = 3'd2;
  localparam logic [2:0] CODE_IDLE           = 3'd3;
  localparam logic [2:0] CODE_LISTEN         = 3'd4;
  localparam logic [2:0] CODE_CHALLENGE_SENT = 3'd5;
  localparam logic [2:0] CODE_SERVER_CONN    = 3'd6;
  localparam logic [2:0] CODE_STALE          = 3'd7;

  // Event kinds.
  localparam logic [1:0] KIND_MSG      = 2'd0;
  localparam logic [1:0] KIND_TIMER    = 2'd1;
  localparam logic [1:0] KIND_LINK_ERR = 2'd2;

  // Message types.
  localparam logic [3:0] MSG_LOGIN     = 4'd0;
  localparam logic [3:0] MSG_CHALLENGE = 4'd1;
  localparam logic [3:0] MSG_RESPONSE  = 4'd2;
  localparam logic [3:0] MSG_AUTH_OK   = 4'd3;
  localparam logic [3:0] MSG_DENY      = 4'd4;
  localparam logic [3:0] MSG_IPCONF    = 4'd5;
  localparam logic [3:0] MSG_KEEPALIVE = 4'd6;
  localparam logic [3:0] MSG_DATA      = 4'd7;
  localparam logic [3:0] MSG_RESET     = 4'd8;

  // Timer actions.
  localparam logic [1:0] TMR_NONE   = 2'd0;
  localparam logic [1:0] TMR_CANCEL = 2'd1;
  localparam logic [1:0] TMR_ARM    = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SERVER_ROLE      = 2'd0;
  localparam logic [1:0] CFG_MAX_RETRIES      = 2'd1;
  localparam logic [1:0] CFG_HANDSHAKE_PERIOD = 2'd2;
  localparam logic [1:0] CFG_KEEPALIVE_PERIOD = 2'd3;

  localparam logic [7:0]  MAX_RETRIES_RST      = 8'd5;
  localparam logic [31:0] HANDSHAKE_PERIOD_RST = 32'd1000;
  localparam logic [31:0] KEEPALIVE_PERIOD_RST = 32'd10000;

  function automatic logic [2:0] state_code(state_e st);
    logic [2:0] code;
    unique case (st)
      ST_LOGIN_SENT:     code = CODE_LOGIN_SENT;
      ST_RESPONSE_SENT:  code = CODE_RESPONSE_SENT;
      ST_CLIENT_CONN:    code = CODE_CLIENT_CONN;
      ST_IDLE:           code = CODE_IDLE;
      ST_LISTEN:         code = CODE_LISTEN;
      ST_CHALLENGE_SENT: code = CODE_CHALLENGE_SENT;
      ST_SERVER_CONN:    code = CODE_SERVER_CONN;
      ST_STALE:          code = CODE_STALE;
      default:           code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: hdl/tunnel_session_handshake_fsm_unit.sv
// Tunnel session handshake engine: one event in, one result out.
// Depends on tshf_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one event per transfer:
//   a received message with its endpoint, challenge and send-status flags,
//   a timer expiry or a link error. Output channel (out_valid_o/out_ready_i)
//   carries exactly one result per event: message to send, next state,
//   timer action and period, data-deliver and session-release flags.
//   Events pass the event register, then the result register. One event
//   per cycle is sustained while out_ready_i is high, since next-state
//   logic reads session state and retry count written on the previous cycle.
//   A stalled receiver holds the result register; the event register still
//   takes one more transfer, then in_ready_o drops until the result leaves.
//   Configuration port cfg_we_i/cfg_idx_i/cfg_wdata_i: the user must use it
//   only while the engine is idle; the block does not enforce this.
//   A role write restarts the session in that role's start state, retries 0.
//   Reset: client role, state idle, retries 0, max_retries 5,
//   handshake period 1000, keepalive period 10000, both channels empty.
`include "assert_macros.svh"

module tunnel_session_handshake_fsm_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // events
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  in_kind_i,
  input  logic [3:0]  in_msg_type_i,
  input  logic        in_endpoint_match_i,
  input  logic        in_challenge_match_i,
  input  logic        in_send_ok_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_send_valid_o,
  output logic [3:0]  out_send_type_o,
  output logic [2:0]  out_next_state_o,
  output logic [1:0]  out_timer_action_o,
  output logic [31:0] out_timer_period_o,
  output logic        out_deliver_data_o,
  output logic        out_session_release_o
);

  // configuration registers
  logic        srv_role_q;
  logic [7:0]  max_retries_q;
  logic [31:0] hs_period_q;
  logic [31:0] ka_period_q;

  // session state
  tshf_pkg::state_e state_q, state_d;
  logic [7:0]       retry_q, retry_d;

  // event register
  logic       ev_valid_q;
  logic [1:0] ev_kind_q;
  logic [3:0] ev_msg_q;
  logic       ev_ep_q;
  logic       ev_chm_q;
  logic       ev_ok_q;

  // result register
  logic        out_valid_q;
  logic        res_sent_q;
  logic [3:0]  res_type_q;
  logic [2:0]  res_state_q;
  logic [1:0]  res_tact_q;
  logic [31:0] res_period_q;
  logic        res_deliver_q;
  logic        res_release_q;

  logic in_fire;
  logic advance;

  assign advance    = ev_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !ev_valid_q || !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srv_role_q    <= 1'b0;
      max_retries_q <= tshf_pkg::MAX_RETRIES_RST;
      hs_period_q   <= tshf_pkg::HANDSHAKE_PERIOD_RST;
      ka_period_q   <= tshf_pkg::KEEPALIVE_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tshf_pkg::CFG_SERVER_ROLE:      srv_role_q    <= cfg_wdata_i[0];
        tshf_pkg::CFG_MAX_RETRIES:      max_retries_q <= cfg_wdata_i[7:0];
        tshf_pkg::CFG_HANDSHAKE_PERIOD: hs_period_q   <= cfg_wdata_i;
        tshf_pkg::CFG_KEEPALIVE_PERIOD: ka_period_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- event register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (in_fire) begin
      ev_valid_q <= 1'b1;
    end else if (advance) begin
      ev_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ev_kind_q <= in_kind_i;
      ev_msg_q  <= in_msg_type_i;
      ev_ep_q   <= in_endpoint_match_i;
      ev_chm_q  <= in_challenge_match_i;
      ev_ok_q   <= in_send_ok_i;
    end
  end

  // ------------------------------------------------------- next-state logic
  logic             msg_take;
  logic             handled;
  logic             arm;
  logic             sent;
  logic [3:0]       stype;
  logic [1:0]       tact;
  logic             deliver;
  logic             release_s;
  logic [8:0]       bump;
  logic [7:0]       bump_sat;
  logic             over_limit;
  logic             client_st;
  tshf_pkg::state_e start_st;
  logic [63:0]      shifted;
  logic [31:0]      period;

  assign start_st   = srv_role_q ? tshf_pkg::ST_LISTEN : tshf_pkg::ST_IDLE;
  assign bump       = {1'b0, retry_q} + 9'd1;
  assign bump_sat   = bump[8] ? 8'hFF : bump[7:0];
  assign over_limit = bump > {1'b0, max_retries_q};
  assign client_st  = state_q == tshf_pkg::ST_LOGIN_SENT ||
                      state_q == tshf_pkg::ST_RESPONSE_SENT ||
                      state_q == tshf_pkg::ST_CLIENT_CONN ||
                      state_q == tshf_pkg::ST_IDLE;
  // a login in listen adopts the sender, so it skips the endpoint check
  assign msg_take   = ev_kind_q == tshf_pkg::KIND_MSG && ev_msg_q <= tshf_pkg::MSG_RESET &&
                      (ev_ep_q || (state_q == tshf_pkg::ST_LISTEN &&
                                   ev_msg_q == tshf_pkg::MSG_LOGIN));

  always_comb begin
    state_d   = state_q;
    retry_d   = retry_q;
    handled   = 1'b1;
    arm       = 1'b1;
    sent      = 1'b0;
    stype     = tshf_pkg::MSG_LOGIN;
    tact      = tshf_pkg::TMR_NONE;
    deliver   = 1'b0;
    release_s = 1'b0;
    if (msg_take) begin
      if (state_q == tshf_pkg::ST_LOGIN_SENT && ev_msg_q == tshf_pkg::MSG_CHALLENGE) begin
        sent    = ev_ok_q;
        stype   = tshf_pkg::MSG_RESPONSE;
        state_d = ev_ok_q ? tshf_pkg::ST_RESPONSE_SENT : tshf_pkg::ST_IDLE;
      end else if (state_q == tshf_pkg::ST_RESPONSE_SENT &&
                   ev_msg_q == tshf_pkg::MSG_AUTH_OK) begin
        retry_d = 8'd0;
        state_d = tshf_pkg::ST_CLIENT_CONN;
      end else if (state_q == tshf_pkg::ST_RESPONSE_SENT &&
                   ev_msg_q == tshf_pkg::MSG_DENY) begin
        retry_d = 8'd0;
        sent    = ev_ok_q;
        stype   = tshf_pkg::MSG_LOGIN;
        state_d = ev_ok_q ? tshf_pkg::ST_LOGIN_SENT : tshf_pkg::ST_IDLE;
      end else if (state_q == tshf_pkg::ST_CLIENT_CONN &&
                   ev_msg_q == tshf_pkg::MSG_IPCONF) begin
        arm = 1'b0;
      end else if ((state_q == tshf_pkg::ST_CLIENT_CONN || state_q == tshf_pkg::ST_IDLE ||
                    state_q == tshf_pkg::ST_SERVER_CONN || state_q == tshf_pkg::ST_STALE) &&
                   ev_msg_q == tshf_pkg::MSG_KEEPALIVE) begin
        retry_d = 8'd0;
      end else if ((state_q == tshf_pkg::ST_CLIENT_CONN || state_q == tshf_pkg::ST_IDLE ||
                    state_q == tshf_pkg::ST_SERVER_CONN) &&
                   ev_msg_q == tshf_pkg::MSG_DATA) begin
        deliver = 1'b1;
        arm     = 1'b0;
      end else if (state_q == tshf_pkg::ST_LISTEN && ev_msg_q == tshf_pkg::MSG_LOGIN) begin
        retry_d = 8'd0;
        sent    = ev_ok_q;
        stype   = tshf_pkg::MSG_CHALLENGE;
        state_d = ev_ok_q ? tshf_pkg::ST_CHALLENGE_SENT : tshf_pkg::ST_STALE;
      end else if (state_q == tshf_pkg::ST_CHALLENGE_SENT &&
                   ev_msg_q == tshf_pkg::MSG_RESPONSE) begin
        // wrong response: timer still rearmed, state kept
        if (ev_chm_q) begin
          sent    = ev_ok_q;
          stype   = tshf_pkg::MSG_AUTH_OK;
          state_d = ev_ok_q ? tshf_pkg::ST_SERVER_CONN : tshf_pkg::ST_STALE;
        end
      end else if ((state_q == tshf_pkg::ST_CHALLENGE_SENT ||
                    state_q == tshf_pkg::ST_STALE) && ev_msg_q == tshf_pkg::MSG_RESET) begin
        state_d = tshf_pkg::ST_STALE;
      end else begin
        handled = 1'b0;
      end
      if (handled) begin
        tact = arm ? tshf_pkg::TMR_ARM : tshf_pkg::TMR_CANCEL;
      end
    end else if (ev_kind_q == tshf_pkg::KIND_TIMER) begin
      if (client_st) begin
        retry_d = bump_sat;
        if (over_limit) begin
          retry_d = 8'd0;
          sent    = ev_ok_q;
          stype   = tshf_pkg::MSG_LOGIN;
          state_d = ev_ok_q ? tshf_pkg::ST_LOGIN_SENT : tshf_pkg::ST_IDLE;
        end else if (state_q == tshf_pkg::ST_IDLE || state_q == tshf_pkg::ST_LOGIN_SENT) begin
          sent    = ev_ok_q;
          stype   = tshf_pkg::MSG_LOGIN;
          state_d = ev_ok_q ? tshf_pkg::ST_LOGIN_SENT : tshf_pkg::ST_IDLE;
        end else if (state_q == tshf_pkg::ST_CLIENT_CONN) begin
          sent  = ev_ok_q;
          stype = tshf_pkg::MSG_KEEPALIVE;
        end
        tact = tshf_pkg::TMR_ARM;
      end else if (state_q == tshf_pkg::ST_STALE) begin
        release_s = 1'b1;
        retry_d   = 8'd0;
        state_d   = start_st;
      end else begin
        // server side keeps the saturated count when it goes stale
        retry_d = bump_sat;
        if (over_limit) begin
          state_d = tshf_pkg::ST_STALE;
        end else if (state_q == tshf_pkg::ST_SERVER_CONN) begin
          sent  = ev_ok_q;
          stype = tshf_pkg::MSG_KEEPALIVE;
        end
        tact = tshf_pkg::TMR_ARM;
      end
    end else if (ev_kind_q == tshf_pkg::KIND_LINK_ERR) begin
      state_d = srv_role_q ? tshf_pkg::ST_STALE : tshf_pkg::ST_IDLE;
    end
  end

  // arm period from the updated state and retry count
  assign shifted = {32'd0, hs_period_q} << retry_d[4:0];

  always_comb begin
    if (tact != tshf_pkg::TMR_ARM) begin
      period = 32'd0;
    end else if (state_d == tshf_pkg::ST_CLIENT_CONN || state_d == tshf_pkg::ST_SERVER_CONN) begin
      period = ka_period_q;
    end else if (hs_period_q == 32'd0) begin
      period = 32'd0;
    end else if (retry_d >= 8'd32 || shifted[63:32] != 32'd0) begin
      period = 32'hFFFF_FFFF;
    end else begin
      period = shifted[31:0];
    end
  end

  // ---------------------------------------------------------- session state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tshf_pkg::ST_IDLE;
      retry_q <= 8'd0;
    end else if (cfg_we_i && cfg_idx_i == tshf_pkg::CFG_SERVER_ROLE) begin
      state_q <= cfg_wdata_i[0] ? tshf_pkg::ST_LISTEN : tshf_pkg::ST_IDLE;
      retry_q <= 8'd0;
    end else if (advance) begin
      state_q <= state_d;
      retry_q <= retry_d;
    end
  end

  // --------------------------------------------------------- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_sent_q    <= sent;
      res_type_q    <= sent ? stype : 4'd0;
      res_state_q   <= tshf_pkg::state_code(state_d);
      res_tact_q    <= tact;
      res_period_q  <= period;
      res_deliver_q <= deliver;
      res_release_q <= release_s;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_send_valid_o      = res_sent_q;
  assign out_send_type_o       = res_type_q;
  assign out_next_state_o      = res_state_q;
  assign out_timer_action_o    = res_tact_q;
  assign out_timer_period_o    = res_period_q;
  assign out_deliver_data_o    = res_deliver_q;
  assign out_session_release_o = res_release_q;

  // -------------------------------------------------------------- assertions
  `TSHF_ASSERT(a_adv_fills_out, advance |=> out_valid_q, "result lost on advance")
  `TSHF_ASSERT(a_period_only_on_arm,
    out_valid_q && res_tact_q != tshf_pkg::TMR_ARM |-> res_period_q == 32'd0,
    "period set without arm")
  `TSHF_ASSERT(a_type_only_when_sent,
    out_valid_q && !res_sent_q |-> res_type_q == 4'd0, "send type without send")
  `TSHF_ASSERT_ALWAYS(a_no_overrun,
    !rst_ni || !(ev_valid_q && out_valid_q && !out_ready_i) || !in_ready_o,
    "event register overrun")

endmodule

FILE: bench/tunnel_session_handshake_fsm_unit_tb.sv
// Self-checking bench for tunnel_session_handshake_fsm_unit: directed and state-guided random
// events, with random gaps and stalls on both channels. Depends on tshf_pkg and the unit RTL.
`timescale 1ns / 100ps

module tunnel_session_handshake_fsm_unit_tb;

  localparam logic [3:0] MSG_UNLISTED = 4'hF;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_EVENTS = 130;
  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct packed {
    logic        sent;
    logic [3:0]  sent_type;
    logic [2:0]  next_code;
    logic [1:0]  tmr_act;
    logic [31:0] tmr_period;
    logic        deliver;
    logic        freed;
  } session_result_t;

  // Mirror of the session: registers, state, retries and the results still owed.
  class session_mirror;
    bit        role_server;
    bit [7:0]  retry_limit;
    bit [31:0] hs_base;
    bit [31:0] ka_base;
    bit [2:0]  sess_code;
    bit [7:0]  retries;
    session_result_t pending_results[$];
    int unsigned n_checked, n_errors, n_freed, n_delivered, n_sent;

    function new();
      role_server = 1'b0;
      retry_limit = tshf_pkg::MAX_RETRIES_RST;
      hs_base = tshf_pkg::HANDSHAKE_PERIOD_RST;
      ka_base = tshf_pkg::KEEPALIVE_PERIOD_RST;
      sess_code = tshf_pkg::CODE_IDLE;
      retries = '0;
    endfunction

    function bit [2:0] start_code();
      return role_server ? tshf_pkg::CODE_LISTEN : tshf_pkg::CODE_IDLE;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        tshf_pkg::CFG_SERVER_ROLE: begin
          role_server = data[0];
          sess_code = start_code();
          retries = '0;
        end
        tshf_pkg::CFG_MAX_RETRIES: retry_limit = data[7:0];
        tshf_pkg::CFG_HANDSHAKE_PERIOD: hs_base = data;
        tshf_pkg::CFG_KEEPALIVE_PERIOD: ka_base = data;
        default: ;
      endcase
    endfunction

    // Count saturates at 255; the returned value may be 256.
    function int unsigned bump_retries();
      int unsigned n;
      n = retries + 1;
      retries = (n > 255) ? 8'd255 : n[7:0];
      return n;
    endfunction

    function void predict_event(logic [1:0] kind, logic [3:0] mt, logic ep, logic chm,
                                logic ok);
      session_result_t r;
      bit [2:0]  st;
      bit        handled;
      bit        arm;
      bit        restart;
      bit [63:0] wide;
      r = '0;
      st = sess_code;
      // login in listen adopts the sender, so the endpoint check does not apply
      if (kind == tshf_pkg::KIND_MSG && mt <= tshf_pkg::MSG_RESET &&
          (ep || (st == tshf_pkg::CODE_LISTEN && mt == tshf_pkg::MSG_LOGIN))) begin
        handled = 1'b1;
        arm = 1'b1;
        if (st == tshf_pkg::CODE_LOGIN_SENT && mt == tshf_pkg::MSG_CHALLENGE) begin
          r.sent = ok;
          r.sent_type = tshf_pkg::MSG_RESPONSE;
          st = ok ? tshf_pkg::CODE_RESPONSE_SENT : tshf_pkg::CODE_IDLE;
        end else if (st == tshf_pkg::CODE_RESPONSE_SENT && mt == tshf_pkg::MSG_AUTH_OK) begin
          retries = '0;
          st = tshf_pkg::CODE_CLIENT_CONN;
        end else if (st == tshf_pkg::CODE_RESPONSE_SENT && mt == tshf_pkg::MSG_DENY) begin
          retries = '0;
          r.sent = ok;
          r.sent_type = tshf_pkg::MSG_LOGIN;
          st = ok ? tshf_pkg::CODE_LOGIN_SENT : tshf_pkg::CODE_IDLE;
        end else if (st == tshf_pkg::CODE_CLIENT_CONN && mt == tshf_pkg::MSG_IPCONF) begin
          arm = 1'b0;
        end else if (mt == tshf_pkg::MSG_KEEPALIVE &&
                     (st == tshf_pkg::CODE_CLIENT_CONN || st == tshf_pkg::CODE_IDLE ||
                      st == tshf_pkg::CODE_SERVER_CONN || st == tshf_pkg::CODE_STALE)) begin
          retries = '0;
        end else if (mt == tshf_pkg::MSG_DATA &&
                     (st == tshf_pkg::CODE_CLIENT_CONN || st == tshf_pkg::CODE_IDLE ||
                      st == tshf_pkg::CODE_SERVER_CONN)) begin
          r.deliver = 1'b1;
          arm = 1'b0;
        end else if (st == tshf_pkg::CODE_LISTEN && mt == tshf_pkg::MSG_LOGIN) begin
          retries = '0;
          r.sent = ok;
          r.sent_type = tshf_pkg::MSG_CHALLENGE;
          st = ok ? tshf_pkg::CODE_CHALLENGE_SENT : tshf_pkg::CODE_STALE;
        end else if (st == tshf_pkg::CODE_CHALLENGE_SENT && mt == tshf_pkg::MSG_RESPONSE) begin
          if (chm) begin
            r.sent = ok;
            r.sent_type = tshf_pkg::MSG_AUTH_OK;
            st = ok ? tshf_pkg::CODE_SERVER_CONN : tshf_pkg::CODE_STALE;
          end
        end else if (mt == tshf_pkg::MSG_RESET &&
                     (st == tshf_pkg::CODE_CHALLENGE_SENT || st == tshf_pkg::CODE_STALE)) begin
          st = tshf_pkg::CODE_STALE;
        end else begin
          handled = 1'b0;
        end
        if (handled) r.tmr_act = arm ? tshf_pkg::TMR_ARM : tshf_pkg::TMR_CANCEL;
      end else if (kind == tshf_pkg::KIND_TIMER) begin
        if (st <= tshf_pkg::CODE_IDLE) begin
          // client side
          restart = bump_retries() > retry_limit;
          if (restart) retries = '0;
          if (restart || st == tshf_pkg::CODE_IDLE || st == tshf_pkg::CODE_LOGIN_SENT) begin
            r.sent = ok;
            r.sent_type = tshf_pkg::MSG_LOGIN;
            st = ok ? tshf_pkg::CODE_LOGIN_SENT : tshf_pkg::CODE_IDLE;
          end else if (st == tshf_pkg::CODE_CLIENT_CONN) begin
            r.sent = ok;
            r.sent_type = tshf_pkg::MSG_KEEPALIVE;
          end
          r.tmr_act = tshf_pkg::TMR_ARM;
        end else if (st == tshf_pkg::CODE_STALE) begin
          r.freed = 1'b1;
          retries = '0;
          st = start_code();
        end else begin
          if (bump_retries() > retry_limit) st = tshf_pkg::CODE_STALE;
          if (st == tshf_pkg::CODE_SERVER_CONN) begin
            r.sent = ok;
            r.sent_type = tshf_pkg::MSG_KEEPALIVE;
          end
          r.tmr_act = tshf_pkg::TMR_ARM;
        end
      end else if (kind == tshf_pkg::KIND_LINK_ERR) begin
        st = role_server ? tshf_pkg::CODE_STALE : tshf_pkg::CODE_IDLE;
      end

      sess_code = st;
      r.next_code = st;
      if (!r.sent) r.sent_type = '0;
      if (r.tmr_act == tshf_pkg::TMR_ARM) begin
        if (st == tshf_pkg::CODE_CLIENT_CONN || st == tshf_pkg::CODE_SERVER_CONN) begin
          r.tmr_period = ka_base;
        end else if (hs_base == 0) begin
          r.tmr_period = '0;
        end else if (retries >= 32) begin
          r.tmr_period = '1;
        end else begin
          wide = {32'd0, hs_base} << retries;
          r.tmr_period = (wide[63:32] != 0) ? '1 : wide[31:0];
        end
      end
      pending_results.push_back(r);
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_result(session_result_t got);
      session_result_t want;
      bit good;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no pending event, got %h", $time, got);
        n_errors++;
        return;
      end
      want = pending_results.pop_front();
      good = field_ok("send_valid", want.sent, got.sent)
           & field_ok("send_type", want.sent_type, got.sent_type)
           & field_ok("next_state", want.next_code, got.next_code)
           & field_ok("timer_action", want.tmr_act, got.tmr_act)
           & field_ok("timer_period", want.tmr_period, got.tmr_period)
           & field_ok("deliver_data", want.deliver, got.deliver)
           & field_ok("session_release", want.freed, got.freed);
      if (!good) n_errors++;
      n_checked++;
      n_sent += want.sent;
      n_delivered += want.deliver;
      n_freed += want.freed;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = tshf_pkg::CFG_SERVER_ROLE;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  in_kind_i = tshf_pkg::KIND_MSG;
  logic [3:0]  in_msg_type_i = tshf_pkg::MSG_LOGIN;
  logic        in_endpoint_match_i = 1'b0;
  logic        in_challenge_match_i = 1'b0;
  logic        in_send_ok_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        out_send_valid_o;
  logic [3:0]  out_send_type_o;
  logic [2:0]  out_next_state_o;
  logic [1:0]  out_timer_action_o;
  logic [31:0] out_timer_period_o;
  logic        out_deliver_data_o;
  logic        out_session_release_o;

  session_mirror mirror;
  bit            tx_steady = 1'b0;
  bit            rx_steady = 1'b0;
  int unsigned   rx_hold = 0;
  int unsigned   storm_left = 0;
  int unsigned   n_events = 0;
  int unsigned   n_settings = 0;
  int unsigned   idle_cycles = 0;

  tunnel_session_handshake_fsm_unit dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned pick_pause(bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      out_ready_i <= 1'b0;
      rx_hold--;
    end else begin
      out_ready_i <= 1'b1;
      rx_hold = pick_pause(rx_steady);
    end
    if ($urandom_range(0, 199) == 0) rx_steady = !rx_steady;
  end

  // Outputs are sampled mid-cycle; the transfer lands on the following rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      mirror.check_result({out_send_valid_o, out_send_type_o, out_next_state_o,
                           out_timer_action_o, out_timer_period_o, out_deliver_data_o,
                           out_session_release_o});
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  task automatic send_event(logic [1:0] kind, logic [3:0] mt, logic ep, logic chm, logic ok);
    int unsigned gap;
    gap = pick_pause(tx_steady);
    if ($urandom_range(0, 99) == 0) tx_steady = !tx_steady;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_kind_i <= kind;
    in_msg_type_i <= mt;
    in_endpoint_match_i <= ep;
    in_challenge_match_i <= chm;
    in_send_ok_i <= ok;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    mirror.predict_event(kind, mt, ep, chm, ok);
    n_events++;
  endtask

  // Always advances at least one edge, so valid is never lowered and raised in one step.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (mirror.pending_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    mirror.write_reg(idx, data);
  endtask

  task automatic configure(bit srv, bit [7:0] maxr, bit [31:0] hs, bit [31:0] ka);
    write_reg(tshf_pkg::CFG_SERVER_ROLE, {31'd0, srv});
    write_reg(tshf_pkg::CFG_MAX_RETRIES, {24'd0, maxr});
    write_reg(tshf_pkg::CFG_HANDSHAKE_PERIOD, hs);
    write_reg(tshf_pkg::CFG_KEEPALIVE_PERIOD, ka);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Mostly the message that moves the session on from where it stands.
  task automatic send_random();
    logic [1:0] kind;
    logic [3:0] mt;
    logic       ep;
    logic       chm;
    logic       ok;
    logic [3:0] menu[$];
    int unsigned r;
    kind = tshf_pkg::KIND_MSG;
    mt = 4'($urandom_range(0, 15));
    ep = ($urandom_range(0, 9) != 0);
    chm = ($urandom_range(0, 7) != 0);
    ok = ($urandom_range(0, 9) != 0);
    r = $urandom_range(0, 99);
    if (storm_left == 0 && $urandom_range(0, 99) == 0) storm_left = $urandom_range(10, 80);
    if (storm_left > 0) begin
      storm_left--;
      kind = tshf_pkg::KIND_TIMER;
    end else if (r < 8) begin
      kind = 2'($urandom_range(0, 3));
      ep = 1'($urandom_range(0, 1));
      chm = 1'($urandom_range(0, 1));
      ok = 1'($urandom_range(0, 1));
    end else if (r < 11) begin
      kind = tshf_pkg::KIND_LINK_ERR;
    end else if (r < 30 || (mirror.sess_code == tshf_pkg::CODE_IDLE && r < 55)) begin
      kind = tshf_pkg::KIND_TIMER;
    end else if ($urandom_range(0, 6) == 0) begin
      mt = 4'($urandom_range(0, tshf_pkg::MSG_RESET));
    end else begin
      case (mirror.sess_code)
        tshf_pkg::CODE_LOGIN_SENT:     menu = '{tshf_pkg::MSG_CHALLENGE};
        tshf_pkg::CODE_RESPONSE_SENT:  menu = '{tshf_pkg::MSG_AUTH_OK, tshf_pkg::MSG_DENY};
        tshf_pkg::CODE_CLIENT_CONN: begin
          menu = '{tshf_pkg::MSG_IPCONF, tshf_pkg::MSG_KEEPALIVE, tshf_pkg::MSG_DATA};
        end
        tshf_pkg::CODE_IDLE:           menu = '{tshf_pkg::MSG_KEEPALIVE, tshf_pkg::MSG_DATA};
        tshf_pkg::CODE_LISTEN:         menu = '{tshf_pkg::MSG_LOGIN};
        tshf_pkg::CODE_CHALLENGE_SENT: begin
          menu = '{tshf_pkg::MSG_RESPONSE, tshf_pkg::MSG_RESPONSE, tshf_pkg::MSG_RESET};
        end
        tshf_pkg::CODE_SERVER_CONN:    menu = '{tshf_pkg::MSG_KEEPALIVE, tshf_pkg::MSG_DATA};
        default:                       menu = '{tshf_pkg::MSG_KEEPALIVE, tshf_pkg::MSG_RESET};
      endcase
      mt = menu[$urandom_range(0, menu.size() - 1)];
    end
    send_event(kind, mt, ep, chm, ok);
  endtask

  initial begin
    bit          srv;
    bit [7:0]    maxr;
    bit [31:0]   hs;
    bit [31:0]   ka;
    mirror = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // client walk-through on reset settings
    send_event(tshf_pkg::KIND_TIMER, tshf_pkg::MSG_LOGIN, 1'b1, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_MSG, tshf_pkg::MSG_CHALLENGE, 1'b1, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_MSG, tshf_pkg::MSG_AUTH_OK, 1'b1, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_MSG, tshf_pkg::MSG_IPCONF, 1'b1, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_MSG, tshf_pkg::MSG_KEEPALIVE, 1'b1, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_MSG, tshf_pkg::MSG_DATA, 1'b1, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_TIMER, tshf_pkg::MSG_DATA, 1'b1, 1'b1, 1'b1);
    send_event(tshf_pkg::KIND_MSG, MSG_UNLISTED, 1'b1, 1'b1, 1'b1);
    send_event(tshf_pkg::KIND_MSG, tshf_pkg::MSG_DATA, 1'b0, 1'b1, 1'b1);
    send_event(KIND_UNKNOWN, MSG_UNLISTED, 1'b1, 1'b1, 1'b1);
    send_event(tshf_pkg::KIND_LINK_ERR, tshf_pkg::MSG_LOGIN, 1'b1, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_TIMER, tshf_pkg::MSG_LOGIN, 1'b1, 1'b0, 1'b0);
    send_event(tshf_pkg::KIND_TIMER, tshf_pkg::MSG_LOGIN, 1'b1, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_MSG, tshf_pkg::MSG_CHALLENGE, 1'b1, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_MSG, tshf_pkg::MSG_DENY, 1'b1, 1'b0, 1'b0);
    wait_drain();

    // server walk-through: endpoint adoption, challenge check, stale and release
    configure(1'b1, 8'd1, 32'hFFFF_FFFF, 32'd1);
    send_event(tshf_pkg::KIND_MSG, tshf_pkg::MSG_LOGIN, 1'b0, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_MSG, tshf_pkg::MSG_RESPONSE, 1'b1, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_MSG, tshf_pkg::MSG_RESPONSE, 1'b1, 1'b1, 1'b1);
    send_event(tshf_pkg::KIND_TIMER, tshf_pkg::MSG_LOGIN, 1'b1, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_TIMER, tshf_pkg::MSG_LOGIN, 1'b1, 1'b0, 1'b0);
    send_event(tshf_pkg::KIND_MSG, tshf_pkg::MSG_KEEPALIVE, 1'b1, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_MSG, tshf_pkg::MSG_RESET, 1'b1, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_TIMER, tshf_pkg::MSG_RESET, 1'b1, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_MSG, tshf_pkg::MSG_LOGIN, 1'b1, 1'b0, 1'b0);
    send_event(tshf_pkg::KIND_LINK_ERR, tshf_pkg::MSG_LOGIN, 1'b1, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_TIMER, tshf_pkg::MSG_LOGIN, 1'b1, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_MSG, tshf_pkg::MSG_LOGIN, 1'b1, 1'b0, 1'b1);
    send_event(tshf_pkg::KIND_MSG, tshf_pkg::MSG_RESPONSE, 1'b1, 1'b1, 1'b0);
    send_event(tshf_pkg::KIND_TIMER, tshf_pkg::MSG_LOGIN, 1'b1, 1'b0, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      srv = p[0];
      case (p)
        0: begin maxr = 8'd0; hs = 32'd1; ka = 32'd1; end
        1: begin maxr = 8'd255; hs = $urandom_range(1, 5000); ka = 32'hFFFF_FFFF; end
        2: begin maxr = 8'd255; hs = $urandom_range(1, 5000); ka = $urandom() | 32'd1; end
        3: begin maxr = 8'd0; hs = $urandom() | 32'd1; ka = $urandom_range(1, 5000); end
        4: begin maxr = 8'($urandom_range(1, 10)); hs = 32'hFFFF_FFFF; ka = 32'd1; end
        5: begin maxr = 8'($urandom_range(1, 10)); hs = 32'd1; ka = $urandom() | 32'd1; end
        6: begin
          maxr = 8'($urandom_range(0, 255));
          hs = $urandom_range(1, 5000);
          ka = $urandom_range(1, 5000);
        end
        default: begin
          maxr = 8'($urandom_range(2, 40));
          hs = $urandom_range(1, 5000);
          ka = $urandom() | 32'd1;
        end
      endcase
      wait_drain();
      configure(srv, maxr, hs, ka);
      // a long timer run in listen drives the retry count to saturation
      storm_left = (srv && maxr == 8'd255) ? 260 : 0;
      for (int k = 0; k < PHASE_EVENTS || storm_left > 0; k++) begin
        if (k == PHASE_EVENTS / 2) wait_drain();
        send_random();
      end
    end
    wait_drain();

    $display("%0d events over %0d register settings, %0d results checked",
             n_events, n_settings, mirror.n_checked);
    $display("messages sent %0d, data deliveries %0d, stale sessions freed %0d",
             mirror.n_sent, mirror.n_delivered, mirror.n_freed);
    if (mirror.n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
